>>> sv/hsc_pkg.sv
package hsc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int INT_BITS  = 8;
    localparam int VAL_BITS  = INT_BITS + FRAC_BITS;
    localparam int IN_BITS   = VAL_BITS + 1;
    localparam int TAIL_BITS = FRAC_BITS + 1;
    localparam int NUM_BITS  = VAL_BITS + FRAC_BITS + 1;
    localparam int DIV_BITS  = VAL_BITS + 1;
    localparam int QB        = VAL_BITS + 2;
    localparam int REM_BITS  = DIV_BITS + 1;
    localparam int CMP_BITS  = DIV_BITS + QB;
    localparam int ADDR_BITS = 4;
    localparam int DATA_BITS = 32;
    localparam int LAT       = QB + 5;

    localparam logic [VAL_BITS-1:0] ONE_V  = VAL_BITS'(1) << FRAC_BITS;
    localparam logic [VAL_BITS-1:0] MAXV   = '1;
    localparam logic [NUM_BITS-1:0] HALF_N = NUM_BITS'(1) << (FRAC_BITS - 1);

    localparam logic CMD_FWD = 1'b0;

    typedef enum logic [1:0] {
        REG_PEAK   = 2'd0,
        REG_TARGET = 2'd1,
        REG_SHLDR  = 2'd2,
        REG_TAIL   = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        RG_PASS,
        RG_FWD_SH,
        RG_FWD_TAIL,
        RG_INV_SH,
        RG_INV_TAIL
    } t_region;

    typedef struct packed {
        logic                use_div;
        logic                add_peak;
        logic                sat;
        logic [VAL_BITS-1:0] direct;
    } t_meta;

endpackage

>>> sv/hdr_shoulder_tone_curve_top.sv
// Pipeline: 26 divider stages, one per quotient bit, plus clamp, multiply, operand,
// range-check and output stages lie between the accepting edge and the o_done cycle.
// Throughput: one request per cycle; busy is always low, the output cannot stall.
// Reset: i_rst_n synchronous active low; clears pipeline valid bits and sets
// registers to peak 1.0, target 1.0, strength 0, tail slope 1.0.
module hdr_shoulder_tone_curve_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hsc_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [hsc_pkg::DATA_BITS-1:0]    pwdata,
    output logic [hsc_pkg::DATA_BITS-1:0]    prdata,
    output logic                             pready,
    input  logic                             start,
    output logic                             busy,
    input  logic                             i_cmd,
    input  logic signed [hsc_pkg::IN_BITS-1:0] i_sample_in,
    output logic                             o_done,
    output logic [hsc_pkg::VAL_BITS-1:0]     o_sample_out,
    output logic                             o_saturated
);
    import hsc_pkg::*;

    logic [VAL_BITS-1:0]  r_peak, r_target;
    logic [FRAC_BITS-1:0] r_shldr;
    logic [TAIL_BITS-1:0] r_tail;
    t_reg_idx             w_idx;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign w_idx  = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak   <= ONE_V;
            r_target <= ONE_V;
            r_shldr  <= '0;
            r_tail   <= TAIL_BITS'(ONE_V);
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                REG_PEAK:   r_peak   <= pwdata[VAL_BITS-1:0];
                REG_TARGET: r_target <= pwdata[VAL_BITS-1:0];
                REG_SHLDR:  r_shldr  <= pwdata[FRAC_BITS-1:0];
                REG_TAIL:   r_tail   <= pwdata[TAIL_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_PEAK:   prdata = DATA_BITS'(r_peak);
            REG_TARGET: prdata = DATA_BITS'(r_target);
            REG_SHLDR:  prdata = DATA_BITS'(r_shldr);
            REG_TAIL:   prdata = DATA_BITS'(r_tail);
            default:    prdata = '0;
        endcase
    end

    // stage 0: clamp
    logic                r0_valid, r0_cmd;
    logic [VAL_BITS-1:0] r0_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r0_valid <= 1'b0;
        else          r0_valid <= start && !busy;
        r0_cmd <= i_cmd;
        r0_v   <= i_sample_in[IN_BITS-1] ? '0 : i_sample_in[VAL_BITS-1:0];
    end

    // stage 1: region and product
    t_region              n1_region;
    logic [VAL_BITS-1:0]  n1_a;
    logic [TAIL_BITS-1:0] n1_b;
    logic                 r1_valid;
    t_region              r1_region;
    logic [VAL_BITS-1:0]  r1_v;
    logic [NUM_BITS-1:0]  r1_prod;

    always_comb begin
        n1_a = '0;
        n1_b = '0;
        if (r0_cmd == CMD_FWD) begin
            if (r0_v <= ONE_V) begin
                n1_region = RG_PASS;
            end else if (r0_v <= r_peak) begin
                n1_region = RG_FWD_SH;
                n1_a      = r0_v - ONE_V;
                n1_b      = {1'b0, r_shldr};
            end else begin
                n1_region = RG_FWD_TAIL;
                n1_a      = r0_v - r_peak;
                n1_b      = r_tail;
            end
        end else begin
            if (r0_v <= ONE_V) begin
                n1_region = RG_PASS;
            end else if (r0_v <= r_target) begin
                n1_region = RG_INV_SH;
                n1_a      = r0_v;
                n1_b      = {1'b0, r_shldr};
            end else begin
                n1_region = RG_INV_TAIL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_valid <= 1'b0;
        else          r1_valid <= r0_valid;
        r1_region <= n1_region;
        r1_v      <= r1_valid ? r0_v : r0_v;
        r1_prod   <= NUM_BITS'(n1_a) * NUM_BITS'(n1_b);
    end

    // stage 2: divider operands
    logic [NUM_BITS-1:0] n2_rnd;
    logic [DIV_BITS-1:0] n2_mq;
    logic [DIV_BITS:0]   n2_sum;
    logic [NUM_BITS-1:0] n2_num;
    logic [DIV_BITS-1:0] n2_den;
    t_meta               n2_meta;
    logic                r2_valid;
    logic [NUM_BITS-1:0] r2_num;
    logic [DIV_BITS-1:0] r2_den;
    t_meta               r2_meta;

    always_comb begin
        n2_rnd  = r1_prod + HALF_N;
        n2_mq   = n2_rnd[NUM_BITS-1:FRAC_BITS];
        n2_sum  = (DIV_BITS+1)'(r_target) + (DIV_BITS+1)'(n2_mq);
        n2_num  = '0;
        n2_den  = DIV_BITS'(1);
        n2_meta = '{use_div: 1'b0, add_peak: 1'b0, sat: 1'b0, direct: r1_v};
        unique case (r1_region)
            RG_PASS: ;
            RG_FWD_SH: begin
                n2_meta.use_div = 1'b1;
                n2_num          = NUM_BITS'({r1_v, {FRAC_BITS{1'b0}}});
                n2_den          = DIV_BITS'(ONE_V) + n2_mq;
            end
            RG_FWD_TAIL: begin
                if (n2_sum > (DIV_BITS+1)'(MAXV)) begin
                    n2_meta.sat    = 1'b1;
                    n2_meta.direct = MAXV;
                end else begin
                    n2_meta.direct = n2_sum[VAL_BITS-1:0];
                end
            end
            RG_INV_SH: begin
                n2_meta.use_div = 1'b1;
                n2_num = NUM_BITS'({r1_v, {FRAC_BITS{1'b0}}}) - r1_prod;
                if (n2_mq < DIV_BITS'(ONE_V)) n2_den = DIV_BITS'(ONE_V) - n2_mq;
            end
            RG_INV_TAIL: begin
                n2_meta.use_div  = 1'b1;
                n2_meta.add_peak = 1'b1;
                n2_num = NUM_BITS'({r1_v - r_target, {FRAC_BITS{1'b0}}});
                if (r_tail != '0) n2_den = DIV_BITS'(r_tail);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_valid <= 1'b0;
        else          r2_valid <= r1_valid;
        r2_num  <= n2_num;
        r2_den  <= n2_den;
        r2_meta <= n2_meta;
    end

    // stage 3 and divider: index 0 is the range check, then one quotient bit per stage
    logic                r_dvalid [0:QB];
    logic [REM_BITS-1:0] r_rem    [0:QB];
    logic [QB-1:0]       r_low    [0:QB];
    logic [QB-1:0]       r_q      [0:QB];
    logic [DIV_BITS-1:0] r_den    [0:QB];
    t_meta               r_meta   [0:QB];
    logic [REM_BITS-1:0] n_trial  [0:QB-1];
    logic                n_qbit   [0:QB-1];
    t_meta               n3_meta;

    always_comb begin
        n3_meta = r2_meta;
        if (r2_meta.use_div &&
            CMP_BITS'({r2_num, 1'b0}) >= {r2_den, {QB{1'b0}}}) n3_meta.sat = 1'b1;
        for (int j = 0; j < QB; j++) begin
            n_trial[j] = {r_rem[j][REM_BITS-2:0], r_low[j][QB-1]};
            n_qbit[j]  = n_trial[j] >= {1'b0, r_den[j]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= QB; j++) r_dvalid[j] <= 1'b0;
        end else begin
            r_dvalid[0] <= r2_valid;
            for (int j = 0; j < QB; j++) r_dvalid[j+1] <= r_dvalid[j];
        end
        r_rem[0]  <= REM_BITS'(r2_num >> (QB - 1));
        r_low[0]  <= {r2_num[QB-2:0], 1'b0};
        r_q[0]    <= '0;
        r_den[0]  <= r2_den;
        r_meta[0] <= n3_meta;
        for (int j = 0; j < QB; j++) begin
            r_rem[j+1]  <= n_qbit[j] ? n_trial[j] - {1'b0, r_den[j]} : n_trial[j];
            r_low[j+1]  <= {r_low[j][QB-2:0], 1'b0};
            r_q[j+1]    <= {r_q[j][QB-2:0], n_qbit[j]};
            r_den[j+1]  <= r_den[j];
            r_meta[j+1] <= r_meta[j];
        end
    end

    // output stage: round half up, add peak, saturate
    logic [QB:0]         n_rq;
    logic [QB-1:0]       n_res;
    logic [QB:0]         n_psum;
    t_meta               n_fin;
    logic [VAL_BITS-1:0] n_out;
    logic                n_sat;

    always_comb begin
        n_fin  = r_meta[QB];
        n_rq   = (QB+1)'(r_q[QB]) + (QB+1)'(1);
        n_res  = n_rq[QB:1];
        n_psum = (QB+1)'(r_peak) + (QB+1)'(n_res);
        n_out  = n_fin.direct;
        n_sat  = n_fin.sat;
        if (n_fin.use_div) begin
            if (n_fin.sat || n_res > QB'(MAXV)) begin
                n_sat = 1'b1;
            end else if (n_fin.add_peak && n_psum > (QB+1)'(MAXV)) begin
                n_sat = 1'b1;
            end
            if (n_sat)              n_out = MAXV;
            else if (n_fin.add_peak) n_out = n_psum[VAL_BITS-1:0];
            else                    n_out = n_res[VAL_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_done <= 1'b0;
        else          o_done <= r_dvalid[QB];
        o_sample_out <= n_out;
        o_saturated  <= n_sat;
    end

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result without matching request");

    a_sat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_saturated) |-> (o_sample_out == MAXV))
        else $error("saturated result not clipped");

    a_div_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dvalid[QB] |-> $past(r_dvalid[0], QB))
        else $error("divider stage valid lost");

endmodule

>>> tb/hdr_shoulder_tone_curve_top_tb.sv
module hdr_shoulder_tone_curve_top_tb;
    import hsc_pkg::*;

    localparam logic CMD_INV = 1'b1;

    typedef struct {
        logic                     cmd;
        logic signed [IN_BITS-1:0] smp;
        logic                     known;
        logic [VAL_BITS-1:0]      want_out;
        logic                     want_sat;
    } t_dir_row;

    typedef struct {
        logic [VAL_BITS-1:0] sample;
        logic                sat;
    } t_mapped;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [ADDR_BITS-1:0]        paddr = '0;
    logic [DATA_BITS-1:0]        pwdata = '0;
    logic [DATA_BITS-1:0]        prdata;
    logic                        pready;
    logic                        start = 1'b0;
    logic                        busy;
    logic                        i_cmd = 1'b0;
    logic signed [IN_BITS-1:0]   i_sample_in = '0;
    logic                        o_done;
    logic [VAL_BITS-1:0]         o_sample_out;
    logic                        o_saturated;

    logic [63:0] cur_peak, cur_target, cur_k, cur_tail;
    t_mapped     pending_q[$];
    t_dir_row    dir_rows[$];
    int          err_cnt = 0;
    int          quiet_from, quiet_to;

    always #6 i_clk = ~i_clk;

    hdr_shoulder_tone_curve_top i_dut (.*);

    task automatic report_err(input string what, input logic [63:0] got, input logic [63:0] exp);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, exp, $time);
        err_cnt++;
    endtask

    function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
        return (a >> FRAC_BITS) * b + (((a & 64'hFFFF) * b + 64'h8000) >> FRAC_BITS);
    endfunction

    function automatic logic [63:0] divr(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q, r;
        q = n / d;
        r = n % d;
        if (r >= d - r) q++;
        return q;
    endfunction

    function automatic t_mapped tone_map(input logic c, input logic signed [IN_BITS-1:0] s);
        logic [63:0] v, one, mx, q, ky, d, sl;
        t_mapped m;
        one = 64'd1 << FRAC_BITS;
        mx = (64'd1 << VAL_BITS) - 1;
        v = s[IN_BITS-1] ? 64'd0 : 64'(s[VAL_BITS-1:0]);
        m.sat = 1'b0;
        if (v <= one) begin
            q = v;
        end else if (c == CMD_FWD) begin
            if (v <= cur_peak) begin
                q = divr(v << FRAC_BITS, one + mulq(v - one, cur_k));
            end else begin
                q = cur_target + mulq(v - cur_peak, cur_tail);
                if (q > mx) begin q = mx; m.sat = 1'b1; end
            end
        end else if (v <= cur_target) begin
            ky = mulq(v, cur_k);
            d = (ky < one) ? one - ky : 0;
            if (d < 1) d = 1;
            q = divr(v * (one - cur_k), d);
            if (q > mx) begin q = mx; m.sat = 1'b1; end
        end else begin
            sl = (cur_tail < 1) ? 1 : cur_tail;
            q = divr((v - cur_target) << FRAC_BITS, sl);
            if (q > mx || cur_peak + q > mx) begin
                q = mx;
                m.sat = 1'b1;
            end else begin
                q = cur_peak + q;
            end
        end
        m.sample = q[VAL_BITS-1:0];
        return m;
    endfunction

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= ADDR_BITS'(4 * int'(idx)); pwdata <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_PEAK:   cur_peak   = val & 32'hFFFFFF;
            REG_TARGET: cur_target = val & 32'hFFFFFF;
            REG_SHLDR:  cur_k      = val & 32'hFFFF;
            REG_TAIL:   cur_tail   = val & 32'h1FFFF;
        endcase
    endtask

    task automatic drain();
        while (pending_q.size() != 0) @(negedge i_clk);
        repeat (LAT + 4) @(negedge i_clk);
    endtask

    // one request, driven at negedge, accepted at next posedge with busy low
    task automatic send_req(input logic c, input logic signed [IN_BITS-1:0] s,
                            input logic chk, input logic [VAL_BITS-1:0] wo,
                            input logic ws, input bit allow_gap);
        t_mapped m;
        if (allow_gap) begin
            while ($urandom_range(99) < 8) begin
                start <= 1'b0;
                @(negedge i_clk);
            end
        end
        start <= 1'b1; i_cmd <= c; i_sample_in <= s;
        do @(posedge i_clk); while (busy);
        m = tone_map(c, s);
        if (chk && (m.sample !== wo || m.sat !== ws))
            report_err("table row", {m.sat, m.sample}, {ws, wo});
        pending_q.push_back(m);
        @(negedge i_clk);
    endtask

    task automatic end_burst();
        start <= 1'b0;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        t_mapped e;
        if (i_rst_n && o_done) begin
            if (pending_q.size() == 0) begin
                report_err("unexpected result", o_sample_out, 0);
            end else begin
                e = pending_q.pop_front();
                if (o_sample_out !== e.sample) report_err("sample_out", o_sample_out, e.sample);
                if (o_saturated !== e.sat) report_err("saturated", o_saturated, e.sat);
            end
        end
    end

    function automatic logic signed [IN_BITS-1:0] rand_sample(input int mode);
        case (mode)
            0: return IN_BITS'($urandom_range(32'h20000));
            1: return IN_BITS'($urandom_range(32'h20000 + cur_peak[31:0]));
            2: return IN_BITS'($urandom_range(32'h40000, 32'hFFFFFF));
            3: return IN_BITS'(-$signed(33'($urandom_range(32'h1000000, 1))));
            default: return IN_BITS'($urandom);
        endcase
    endfunction

    task automatic random_run(input int n);
        for (int i = 0; i < n; i++)
            send_req(1'($urandom), rand_sample($urandom_range(5)), 1'b0, '0, 1'b0,
                     !(i >= quiet_from && i < quiet_to));
        end_burst();
    endtask

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        cur_peak = 64'h10000; cur_target = 64'h10000; cur_k = 0; cur_tail = 64'h10000;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset coefficients: identity below 1.0, unit-slope tail above
        dir_rows = '{
            '{CMD_FWD, 25'sd0,          1'b1, 24'd0,        1'b0},
            '{CMD_FWD, 25'sh10000,      1'b1, 24'h10000,    1'b0},
            '{CMD_FWD, 25'sh0FFFFFF,    1'b1, 24'hFFFFFF,   1'b0},
            '{CMD_FWD, -25'sd1,         1'b1, 24'd0,        1'b0},
            '{CMD_FWD, -25'sh1000000,   1'b1, 24'd0,        1'b0},
            '{CMD_INV, 25'sd1,          1'b1, 24'd1,        1'b0},
            '{CMD_INV, 25'sh0FFFFFF,    1'b1, 24'hFFFFFF,   1'b0},
            '{CMD_INV, -25'sd5,         1'b1, 24'd0,        1'b0},
            '{CMD_FWD, 25'sh0123456,    1'b0, 24'd0,        1'b0},
            '{CMD_INV, 25'sh0AAAAAA,    1'b0, 24'd0,        1'b0}
        };
        foreach (dir_rows[i])
            send_req(dir_rows[i].cmd, dir_rows[i].smp, dir_rows[i].known,
                     dir_rows[i].want_out, dir_rows[i].want_sat, 1'b0);
        end_burst();
        drain();

        // strong shoulder with unit-slope tail: saturation and divisor floor
        reg_write(REG_PEAK, 32'h40000);
        reg_write(REG_TARGET, 32'h30000);
        reg_write(REG_SHLDR, 32'hFFFF);
        reg_write(REG_TAIL, 32'h10000);
        dir_rows = '{
            '{CMD_FWD, 25'sh0FFFFFF, 1'b1, 24'hFEFFFF, 1'b0},
            '{CMD_INV, 25'sh0FFFFFF, 1'b1, 24'hFFFFFF, 1'b1},
            '{CMD_INV, 25'sh0030000, 1'b0, 24'd0, 1'b0},
            '{CMD_INV, 25'sh0020000, 1'b0, 24'd0, 1'b0},
            '{CMD_FWD, 25'sh0040000, 1'b0, 24'd0, 1'b0},
            '{CMD_FWD, 25'sh0010001, 1'b0, 24'd0, 1'b0}
        };
        foreach (dir_rows[i])
            send_req(dir_rows[i].cmd, dir_rows[i].smp, dir_rows[i].known,
                     dir_rows[i].want_out, dir_rows[i].want_sat, 1'b0);
        end_burst();
        drain();

        // zero tail slope floors to one LSB; max peak
        reg_write(REG_TAIL, 32'h0);
        reg_write(REG_PEAK, 32'hFFFFFF);
        reg_write(REG_TARGET, 32'h20000);
        reg_write(REG_SHLDR, 32'h0);
        send_req(CMD_INV, 25'sh0FFFFFF, 1'b0, '0, 1'b0, 1'b0);
        send_req(CMD_FWD, 25'sh0800000, 1'b0, '0, 1'b0, 1'b0);
        end_burst();
        drain();

        for (int ph = 0; ph < 6; ph++) begin
            reg_write(REG_PEAK, $urandom_range(32'hFFFFFF, ph == 0 ? 0 : 32'h10000));
            reg_write(REG_TARGET, $urandom_range(32'hFFFFFF, ph == 1 ? 0 : 32'h10000));
            reg_write(REG_SHLDR, $urandom_range(32'hFFFF));
            reg_write(REG_TAIL, ph == 2 ? 32'h1FFFF : $urandom_range(32'h10000));
            quiet_from = (ph == 3) ? 20 : 0;
            quiet_to = (ph == 3) ? 180 : 0;
            random_run(215);
            drain();
        end

        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

>>> sim.f
sv/hsc_pkg.sv
sv/hdr_shoulder_tone_curve_top.sv
tb/hdr_shoulder_tone_curve_top_tb.sv
